// ===== src/trailer_status_can_reporter_top_defines.svh =====
// ----------------------------------------------------------------------------
// trailer status reporter assertion macros
// shared property forms for the reporter modules
// ----------------------------------------------------------------------------
`ifndef TRAILER_STATUS_CAN_REPORTER_TOP_DEFINES_SVH
`define TRAILER_STATUS_CAN_REPORTER_TOP_DEFINES_SVH

// same-cycle implication
`define TSCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tscr assertion failed");

// next-cycle implication
`define TSCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tscr assertion failed");

`endif

// ===== src/tscr_pkg.sv =====
// ----------------------------------------------------------------------------
// tscr_pkg
// types, register codes and constants of the trailer status reporter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tscr_pkg;

	localparam int ADC_BITS_DEF  = 12;
	localparam int TIME_BITS_DEF = 48;

	localparam int FULL_SCALE_MV = 3300;

	localparam int MV_W       = 12;
	localparam int ID_W       = 11;
	localparam int PERIOD_W   = 24;
	localparam int LIMIT_W    = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_FRAME_ID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PERIOD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_PERIOD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_THRESH   = 3'd4;

	// register reset values
	localparam logic [ID_W-1:0]     RST_STATUS_FRAME_ID = 11'h010;
	localparam logic [PERIOD_W-1:0] RST_ACTIVE_PERIOD   = 24'd33000;
	localparam logic [PERIOD_W-1:0] RST_PROBE_PERIOD    = 24'd2000000;
	localparam logic [LIMIT_W-1:0]  RST_FAIL_LIMIT      = 8'd3;
	localparam logic [MV_W-1:0]     RST_CONNECT_THRESH  = 12'd500;

	localparam logic [LIMIT_W-1:0] FAIL_MAX = 8'hFF;

	// result kinds
	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_RECOVER = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]     status_frame_id;
		logic [PERIOD_W-1:0] active_period;
		logic [PERIOD_W-1:0] probe_period;
		logic [LIMIT_W-1:0]  fail_limit;
		logic [MV_W-1:0]     connect_thresh;
	} cfg_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [ID_W-1:0] frame_id;
		logic [4:0]      flag_byte;
		logic [MV_W-1:0] voltage;
		logic            last;
	} result_t;

	localparam result_t RESULT_NONE = '0;

	// up to two results written to the output queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== src/tscr_core.sv =====
// ----------------------------------------------------------------------------
// tscr_core
// input register, sample scaling and bus supervision state machine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trailer_status_can_reporter_top_defines.svh"

module tscr_core
	import tscr_pkg::*;
#(
	parameter int ADC_BITS  = ADC_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [ADC_BITS-1:0]  adc_code,
	input  logic [3:0]           pin_levels,
	input  logic                 alert_bus_off,
	input  logic                 alert_recovered,
	input  logic                 alert_tx_failed,
	input  logic                 alert_tx_success,
	input  logic                 alert_rx_data,
	input  logic [TIME_BITS-1:0] now_us,
	input  logic [1:0]           room,
	output push_t                push
);

	// mv = code * 3300 / (2^N - 1) as a reciprocal multiply plus one correction step
	localparam int unsigned ADC_MAX = (2 ** ADC_BITS) - 1;
	localparam int P_W    = ADC_BITS + MV_W;
	localparam int SHIFT  = P_W;
	localparam int unsigned RECIP = (2 ** SHIFT) / ADC_MAX;
	localparam int K_W    = 25;
	localparam int unsigned SCALE_K = FULL_SCALE_MV * RECIP;
	localparam int PROD_W = ADC_BITS + K_W;

	logic                 vld_s1;
	logic                 cmd_s1;
	logic [3:0]           pins_s1;
	logic                 boff_s1;
	logic                 rec_s1;
	logic                 txf_s1;
	logic                 txs_s1;
	logic                 rx_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [P_W-1:0]       p_s1;
	logic [PROD_W-1:0]    pk_s1;

	logic                 bus_down_q;
	logic                 probing_q;
	logic [LIMIT_W-1:0]   fail_q;
	logic [TIME_BITS-1:0] last_send_q;
	logic [MV_W-1:0]      volt_q;
	logic [4:0]           light_q;

	logic [P_W-1:0]       p_d;
	logic [PROD_W-1:0]    pk_d;
	logic [MV_W-1:0]      q_est;
	logic [P_W-1:0]       qm;
	logic [P_W-1:0]       rem;
	logic [MV_W-1:0]      mv;
	logic [4:0]           flags;

	logic                 bd_n;
	logic                 pr_n;
	logic [LIMIT_W-1:0]   fc_n;
	logic [TIME_BITS-1:0] elapsed;
	logic [PERIOD_W-1:0]  period;
	logic                 send;
	logic [1:0]           nres;
	logic                 process;
	result_t              res_recover;
	result_t              res_restart;
	result_t              res_status;
	result_t              r0;
	result_t              r1;

	// both products depend on the code only, so they are formed before the input register
	assign p_d  = P_W'({{MV_W{1'b0}}, adc_code} * P_W'(FULL_SCALE_MV));
	assign pk_d = {{K_W{1'b0}}, adc_code} * PROD_W'(SCALE_K);

	assign in_stall = vld_s1 && !process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= cmd;
			pins_s1 <= pin_levels;
			boff_s1 <= alert_bus_off;
			rec_s1  <= alert_recovered;
			txf_s1  <= alert_tx_failed;
			txs_s1  <= alert_tx_success;
			rx_s1   <= alert_rx_data;
			now_s1  <= now_us;
			p_s1    <= p_d;
			pk_s1   <= pk_d;
		end
	end

	// estimate is exact or one low
	assign q_est = pk_s1[SHIFT +: MV_W];
	assign qm    = {q_est, {ADC_BITS{1'b0}}} - P_W'(q_est);
	assign rem   = p_s1 - qm;
	assign mv    = q_est + MV_W'(rem >= P_W'(ADC_MAX));

	assign flags = {!pins_s1[2], !pins_s1[3], !pins_s1[1], !pins_s1[0],
		(mv > cfg.connect_thresh)};

	always_comb begin
		res_recover      = RESULT_NONE;
		res_recover.kind = KIND_RECOVER;
		res_restart      = RESULT_NONE;
		res_restart.kind = KIND_RESTART;
		res_status.kind      = KIND_STATUS;
		res_status.frame_id  = cfg.status_frame_id;
		res_status.flag_byte = light_q;
		res_status.voltage   = volt_q;
		res_status.last      = 1'b0;

		bd_n    = bus_down_q;
		pr_n    = probing_q;
		fc_n    = fail_q;
		send    = 1'b0;
		nres    = 2'd0;
		r0      = RESULT_NONE;
		r1      = RESULT_NONE;
		period  = cfg.active_period;
		elapsed = now_s1 - last_send_q;

		if (boff_s1) begin
			bd_n    = 1'b1;
			nres    = 2'd1;
			r0      = res_recover;
			r0.last = 1'b1;
		end else begin
			if (rec_s1) begin
				bd_n = 1'b0;
				fc_n = '0;
				pr_n = 1'b1;
			end
			if (txf_s1 && !pr_n) begin
				if (fc_n != FAIL_MAX) begin
					fc_n = fc_n + LIMIT_W'(1);
				end
				if (fc_n >= cfg.fail_limit) begin
					pr_n = 1'b1;
				end
			end
			if (txs_s1) begin
				pr_n = 1'b0;
				fc_n = '0;
			end
			if (rx_s1 && pr_n) begin
				pr_n = 1'b0;
				fc_n = '0;
			end
			period = pr_n ? cfg.probe_period : cfg.active_period;
			send   = !bd_n && (elapsed >= TIME_BITS'(period));

			if (rec_s1 && send) begin
				nres    = 2'd2;
				r0      = res_restart;
				r1      = res_status;
				r1.last = 1'b1;
			end else if (rec_s1) begin
				nres    = 2'd1;
				r0      = res_restart;
				r0.last = 1'b1;
			end else if (send) begin
				nres    = 2'd1;
				r0      = res_status;
				r0.last = 1'b1;
			end
		end

		if (!cmd_s1) begin
			nres = 2'd0;
			send = 1'b0;
		end
	end

	assign process    = vld_s1 && (nres <= room);
	assign push.count = process ? nres : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_down_q  <= 1'b0;
			probing_q   <= 1'b0;
			fail_q      <= '0;
			last_send_q <= '0;
			volt_q      <= '0;
			light_q     <= '0;
		end else if (process) begin
			if (cmd_s1) begin
				bus_down_q <= bd_n;
				probing_q  <= pr_n;
				fail_q     <= fc_n;
				if (send) begin
					last_send_q <= now_s1;
				end
			end else begin
				volt_q  <= mv;
				light_q <= flags;
			end
		end
	end

	`TSCR_ASSERT_IMP(a_push_fits, clk, arst_n, push.count != 2'd0, push.count <= room)
	`TSCR_ASSERT_NXT(a_send_time, clk, arst_n, process && send, last_send_q == $past(now_s1))

endmodule

// ===== src/tscr_outq.sv =====
// ----------------------------------------------------------------------------
// tscr_outq
// two-entry result queue between the core and the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trailer_status_can_reporter_top_defines.svh"

module tscr_outq
	import tscr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       out_stall,
	output logic       out_valid,
	output result_t    head,
	output logic [1:0] room
);

	logic [1:0] cnt_q;
	result_t    ent_q [2];
	result_t    nxt   [2];
	logic       pop;
	logic [1:0] c_after;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = ent_q[0];
	assign pop       = out_valid && !out_stall;
	assign c_after   = cnt_q - {1'b0, pop};
	assign room      = 2'd2 - c_after;

	always_comb begin
		nxt[0] = ent_q[0];
		nxt[1] = ent_q[1];
		if (pop) begin
			nxt[0] = ent_q[1];
		end
		if (push.count != 2'd0) begin
			nxt[c_after[0]] = push.r0;
		end
		// a pair is only pushed into an empty queue
		if (push.count == 2'd2) begin
			nxt[1] = push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= c_after + push.count;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= nxt[0];
		ent_q[1] <= nxt[1];
	end

	`TSCR_ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 2'd2 && !pop, push.count == 2'd0)
	`TSCR_ASSERT_IMP(a_last_order, clk, arst_n, push.count == 2'd2, !push.r0.last && push.r1.last)

endmodule

// ===== src/trailer_status_can_reporter_top.sv =====
// ----------------------------------------------------------------------------
// trailer_status_can_reporter_top
// trailer voltage and light sampling with periodic CAN status frames
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   cmd, adc_code, pin_levels, alert_*, now_us
//  output   out        out_valid / out_stall kind, frame_id, flag_byte, voltage_hi/lo, last
//  config   in         cfg_wr_en             cfg_index, cfg_data
//
//  a transaction enters the input register and is resolved from there once the queue has room;
//  its 0, 1 or 2 results land in a two-entry queue and leave one per cycle while out_stall is low.
//  sustained rate is set by the single-result output port; out_valid rises once the results
//  of an item are written into the queue registers.
//  reset clears control state and loads the register defaults; no clearing pass.
//  in_stall rises only while the queue lacks room for the pending item's results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trailer_status_can_reporter_top
	import tscr_pkg::*;
#(
	parameter int ADC_BITS  = ADC_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [ADC_BITS-1:0]   adc_code,
	input  logic [3:0]            pin_levels,
	input  logic                  alert_bus_off,
	input  logic                  alert_recovered,
	input  logic                  alert_tx_failed,
	input  logic                  alert_tx_success,
	input  logic                  alert_rx_data,
	input  logic [TIME_BITS-1:0]  now_us,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            kind,
	output logic [ID_W-1:0]       frame_id,
	output logic [4:0]            flag_byte,
	output logic [7:0]            voltage_hi,
	output logic [7:0]            voltage_lo,
	output logic                  last
);

	cfg_t       cfg_q;
	push_t      push;
	result_t    head;
	logic [1:0] room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.status_frame_id <= RST_STATUS_FRAME_ID;
			cfg_q.active_period   <= RST_ACTIVE_PERIOD;
			cfg_q.probe_period    <= RST_PROBE_PERIOD;
			cfg_q.fail_limit      <= RST_FAIL_LIMIT;
			cfg_q.connect_thresh  <= RST_CONNECT_THRESH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STATUS_FRAME_ID: cfg_q.status_frame_id <= cfg_data[ID_W-1:0];
				REG_ACTIVE_PERIOD:   cfg_q.active_period   <= cfg_data[PERIOD_W-1:0];
				REG_PROBE_PERIOD:    cfg_q.probe_period    <= cfg_data[PERIOD_W-1:0];
				REG_FAIL_LIMIT:      cfg_q.fail_limit      <= cfg_data[LIMIT_W-1:0];
				REG_CONNECT_THRESH:  cfg_q.connect_thresh  <= cfg_data[MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tscr_core #(
		.ADC_BITS  (ADC_BITS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.adc_code         (adc_code),
		.pin_levels       (pin_levels),
		.alert_bus_off    (alert_bus_off),
		.alert_recovered  (alert_recovered),
		.alert_tx_failed  (alert_tx_failed),
		.alert_tx_success (alert_tx_success),
		.alert_rx_data    (alert_rx_data),
		.now_us           (now_us),
		.room             (room),
		.push             (push)
	);

	tscr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign kind       = head.kind;
	assign frame_id   = head.frame_id;
	assign flag_byte  = head.flag_byte;
	assign voltage_hi = {4'b0000, head.voltage[MV_W-1:8]};
	assign voltage_lo = head.voltage[7:0];
	assign last       = head.last;

endmodule

// ===== sim/trailer_status_can_reporter_top_test.sv =====
// ----------------------------------------------------------------------------
// trailer_status_can_reporter_top_test
// self-checking bench: sample and service transactions are driven through the
// valid/stall input channel, every result leaving the output channel is
// compared field by field against a cycle-free model of the reporter that is
// kept inside a small scoreboard class, under several register settings and
// with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trailer_status_can_reporter_top_test;
	import tscr_pkg::*;

	localparam int ADC_FULL     = (1 << ADC_BITS_DEF) - 1;
	localparam int TW           = TIME_BITS_DEF;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASES       = 5;
	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_LIMIT   = 4000;

	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_SERVICE = 1'b1;

	// alert bit masks of one service transaction
	localparam logic [4:0] AL_NONE       = 5'b00000;
	localparam logic [4:0] AL_BUS_OFF    = 5'b10000;
	localparam logic [4:0] AL_RECOVERED  = 5'b01000;
	localparam logic [4:0] AL_TX_FAILED  = 5'b00100;
	localparam logic [4:0] AL_TX_SUCCESS = 5'b00010;
	localparam logic [4:0] AL_RX_DATA    = 5'b00001;

	// no register sits at this index
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic                    cmd;
		logic [ADC_BITS_DEF-1:0] adc;
		logic [3:0]              pins;
		logic [4:0]              alerts;
		logic [TW-1:0]           now;
	} item_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [ID_W-1:0] frame_id;
		logic [4:0]      flag_byte;
		logic [7:0]      voltage_hi;
		logic [7:0]      voltage_lo;
		logic            last;
	} frame_t;

	class report_scoreboard;
		cfg_t           regs;
		bit             bus_down;
		bit             probing;
		logic [7:0]     fail_count;
		logic [TW-1:0]  last_send;
		logic [MV_W-1:0] volt_mv;
		logic [4:0]     lights;
		frame_t         pending_frames[$];
		int             failures;

		function new();
			regs.status_frame_id = RST_STATUS_FRAME_ID;
			regs.active_period   = RST_ACTIVE_PERIOD;
			regs.probe_period    = RST_PROBE_PERIOD;
			regs.fail_limit      = RST_FAIL_LIMIT;
			regs.connect_thresh  = RST_CONNECT_THRESH;
			bus_down   = 1'b0;
			probing    = 1'b0;
			fail_count = '0;
			last_send  = '0;
			volt_mv    = '0;
			lights     = '0;
			failures   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_STATUS_FRAME_ID: regs.status_frame_id = data[ID_W-1:0];
				REG_ACTIVE_PERIOD:   regs.active_period   = data[PERIOD_W-1:0];
				REG_PROBE_PERIOD:    regs.probe_period    = data[PERIOD_W-1:0];
				REG_FAIL_LIMIT:      regs.fail_limit      = data[LIMIT_W-1:0];
				REG_CONNECT_THRESH:  regs.connect_thresh  = data[MV_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PERIOD_W-1:0] period_now();
			return probing ? regs.probe_period : regs.active_period;
		endfunction

		function int pending();
			return pending_frames.size();
		endfunction

		function void note_item(item_t it);
			int unsigned   scaled;
			logic [4:0]    flags;
			logic [TW-1:0] elapsed;
			frame_t        restart_f;
			frame_t        status_f;
			bit            have_restart;
			bit            have_status;
			have_restart = 1'b0;
			have_status  = 1'b0;
			if (it.cmd == CMD_SAMPLE) begin
				scaled = (int'(it.adc) * FULL_SCALE_MV) / ADC_FULL;
				flags = '0;
				if (scaled > regs.connect_thresh) flags[0] = 1'b1;
				if (!it.pins[0]) flags[1] = 1'b1;
				if (!it.pins[1]) flags[2] = 1'b1;
				if (!it.pins[3]) flags[3] = 1'b1;
				if (!it.pins[2]) flags[4] = 1'b1;
				volt_mv = scaled[MV_W-1:0];
				lights  = flags;
				return;
			end
			// bus-off ends the service step after the recovery request
			if ((it.alerts & AL_BUS_OFF) != 0) begin
				bus_down = 1'b1;
				pending_frames.push_back('{KIND_RECOVER, '0, '0, '0, '0, 1'b1});
				return;
			end
			if ((it.alerts & AL_RECOVERED) != 0) begin
				restart_f    = '{KIND_RESTART, '0, '0, '0, '0, 1'b0};
				have_restart = 1'b1;
				bus_down     = 1'b0;
				fail_count   = '0;
				probing      = 1'b1;
			end
			if ((it.alerts & AL_TX_FAILED) != 0 && !probing) begin
				if (fail_count != FAIL_MAX) fail_count = fail_count + 8'd1;
				if (fail_count >= regs.fail_limit) probing = 1'b1;
			end
			if ((it.alerts & AL_TX_SUCCESS) != 0) begin
				probing    = 1'b0;
				fail_count = '0;
			end
			if ((it.alerts & AL_RX_DATA) != 0 && probing) begin
				probing    = 1'b0;
				fail_count = '0;
			end
			elapsed = it.now - last_send;
			if (!bus_down && elapsed >= {{(TW-PERIOD_W){1'b0}}, period_now()}) begin
				last_send   = it.now;
				status_f    = '{KIND_STATUS, regs.status_frame_id, lights,
					{4'b0000, volt_mv[11:8]}, volt_mv[7:0], 1'b1};
				have_status = 1'b1;
			end
			if (have_restart) begin
				restart_f.last = !have_status;
				pending_frames.push_back(restart_f);
			end
			if (have_status) pending_frames.push_back(status_f);
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (pending_frames.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result kind=%0d id=%h flags=%h volt=%h%h last=%b",
						$realtime, got.kind, got.frame_id, got.flag_byte,
						got.voltage_hi, got.voltage_lo, got.last);
				return;
			end
			want = pending_frames.pop_front();
			if (got.kind !== want.kind || got.frame_id !== want.frame_id ||
					got.flag_byte !== want.flag_byte || got.voltage_hi !== want.voltage_hi ||
					got.voltage_lo !== want.voltage_lo || got.last !== want.last) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: mismatch kind=%0d/%0d id=%h/%h flags=%h/%h", $realtime,
						want.kind, got.kind, want.frame_id, got.frame_id,
						want.flag_byte, got.flag_byte);
					$display("    volt=%h%h/%h%h last=%b/%b (expected/actual)",
						want.voltage_hi, want.voltage_lo, got.voltage_hi, got.voltage_lo,
						want.last, got.last);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    cmd;
	logic [ADC_BITS_DEF-1:0] adc_code;
	logic [3:0]              pin_levels;
	logic                    alert_bus_off;
	logic                    alert_recovered;
	logic                    alert_tx_failed;
	logic                    alert_tx_success;
	logic                    alert_rx_data;
	logic [TW-1:0]           now_us;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              kind;
	logic [ID_W-1:0]         frame_id;
	logic [4:0]              flag_byte;
	logic [7:0]              voltage_hi;
	logic [7:0]              voltage_lo;
	logic                    last;

	report_scoreboard sb;
	int               gap_pct;
	int               stall_pct;
	int               fail_pct;
	int               idle_cycles;
	logic [TW-1:0]    clock_us;

	trailer_status_can_reporter_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.adc_code         (adc_code),
		.pin_levels       (pin_levels),
		.alert_bus_off    (alert_bus_off),
		.alert_recovered  (alert_recovered),
		.alert_tx_failed  (alert_tx_failed),
		.alert_tx_success (alert_tx_success),
		.alert_rx_data    (alert_rx_data),
		.now_us           (now_us),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.frame_id         (frame_id),
		.flag_byte        (flag_byte),
		.voltage_hi       (voltage_hi),
		.voltage_lo       (voltage_lo),
		.last             (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_frame('{kind, frame_id, flag_byte, voltage_hi, voltage_lo, last});
	end

	// watchdog on cycles without any transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function item_t sample_item(logic [ADC_BITS_DEF-1:0] adc, logic [3:0] pins);
		item_t it;
		it.cmd    = CMD_SAMPLE;
		it.adc    = adc;
		it.pins   = pins;
		it.alerts = 5'($urandom_range(31));
		it.now    = TW'({$urandom, $urandom});
		return it;
	endfunction

	function item_t service_item(logic [4:0] alerts, logic [TW-1:0] at_us);
		item_t it;
		it.cmd    = CMD_SERVICE;
		it.adc    = ADC_BITS_DEF'($urandom_range(ADC_FULL));
		it.pins   = 4'($urandom_range(15));
		it.alerts = alerts;
		it.now    = at_us;
		return it;
	endfunction

	// mostly forward time, aimed at the send boundary now and then
	function logic [TW-1:0] next_time();
		logic [TW-1:0] p;
		logic [TW-1:0] cap;
		logic [TW-1:0] cand;
		logic [TW-1:0] ahead;
		int unsigned   sel;
		p   = {{(TW-PERIOD_W){1'b0}}, sb.period_now()};
		sel = $urandom_range(19);
		if (sel < 2) begin
			cand = clock_us;
		end else if (sel < 5) begin
			cand  = sb.last_send + p + $urandom_range(2) - 1;
			ahead = cand - clock_us;
			if (ahead[TW-1]) cand = clock_us + 1;
		end else if (sel < 18) begin
			cap = p << 1;
			if (cap > (48'd1 << 26)) cap = 48'd1 << 26;
			if (cap < 3) cap = TW'(3);
			cand = clock_us + $urandom_range(cap[31:0]);
		end else if (sel == 18) begin
			cand = clock_us + TW'({$urandom, $urandom});
		end else begin
			cand = clock_us - $urandom_range(50, 1);
		end
		clock_us = cand;
		return cand;
	endfunction

	function item_t random_item();
		item_t         it;
		int unsigned   r;
		int unsigned   sel;
		int unsigned   near;
		logic [4:0]    al;
		int            succ_pct;
		r = $urandom_range(99);
		if (r < 25) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				it = sample_item('0, 4'($urandom_range(15)));
			end else if (sel == 1) begin
				it = sample_item(ADC_BITS_DEF'(ADC_FULL), 4'($urandom_range(15)));
			end else if (sel < 4) begin
				near = (int'(sb.regs.connect_thresh) * ADC_FULL) / FULL_SCALE_MV
					+ $urandom_range(2);
				if (near > ADC_FULL) near = ADC_FULL;
				it = sample_item(ADC_BITS_DEF'(near), 4'($urandom_range(15)));
			end else begin
				it = sample_item(ADC_BITS_DEF'($urandom_range(ADC_FULL)),
					4'($urandom_range(15)));
			end
		end else if (r < 33) begin
			it = service_item(5'($urandom_range(31)), next_time());
		end else begin
			succ_pct = (fail_pct > 50) ? 2 : 15;
			al = AL_NONE;
			if ($urandom_range(99) < 4) al |= AL_BUS_OFF;
			if ($urandom_range(99) < (sb.bus_down ? 45 : 5)) al |= AL_RECOVERED;
			if ($urandom_range(99) < fail_pct) al |= AL_TX_FAILED;
			if ($urandom_range(99) < succ_pct) al |= AL_TX_SUCCESS;
			if ($urandom_range(99) < succ_pct) al |= AL_RX_DATA;
			it = service_item(al, next_time());
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid         <= 1'b1;
		cmd              <= it.cmd;
		adc_code         <= it.adc;
		pin_levels       <= it.pins;
		alert_bus_off    <= |(it.alerts & AL_BUS_OFF);
		alert_recovered  <= |(it.alerts & AL_RECOVERED);
		alert_tx_failed  <= |(it.alerts & AL_TX_FAILED);
		alert_tx_success <= |(it.alerts & AL_TX_SUCCESS);
		alert_rx_data    <= |(it.alerts & AL_RX_DATA);
		now_us           <= it.now;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// junk above a register's width must be dropped
	task automatic set_config(input logic [ID_W-1:0] id, input logic [PERIOD_W-1:0] act,
			input logic [PERIOD_W-1:0] probe, input logic [LIMIT_W-1:0] limit,
			input logic [MV_W-1:0] thresh, input bit junk);
		logic [CFG_DATA_W-1:0] hi;
		hi = junk ? CFG_DATA_W'($urandom) : '0;
		write_reg(REG_STATUS_FRAME_ID, {hi[CFG_DATA_W-1:ID_W], id});
		write_reg(REG_ACTIVE_PERIOD, act);
		write_reg(REG_PROBE_PERIOD, probe);
		write_reg(REG_FAIL_LIMIT, {hi[CFG_DATA_W-1:LIMIT_W], limit});
		write_reg(REG_CONNECT_THRESH, {hi[CFG_DATA_W-1:MV_W], thresh});
		if (junk) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int rnd_idx;
		sb = new();
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		cmd              = CMD_SAMPLE;
		adc_code         = '0;
		pin_levels       = '0;
		alert_bus_off    = 1'b0;
		alert_recovered  = 1'b0;
		alert_tx_failed  = 1'b0;
		alert_tx_success = 1'b0;
		alert_rx_data    = 1'b0;
		now_us           = '0;
		out_stall        = 1'b0;
		gap_pct          = 0;
		stall_pct        = 30;
		fail_pct         = 30;
		idle_cycles      = 0;
		clock_us         = '0;
		rnd_idx          = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset register values
		send_item(sample_item('0, 4'hF));
		send_item(sample_item(ADC_BITS_DEF'(ADC_FULL), 4'h0));
		send_item(service_item(AL_NONE, 48'd0));
		send_item(service_item(AL_NONE, 48'd33000));
		send_item(service_item(AL_TX_FAILED, 48'd33000));
		send_item(service_item(AL_TX_FAILED, 48'd33000));
		send_item(service_item(AL_TX_FAILED, 48'd33000));
		send_item(service_item(AL_NONE, 48'd2032999));
		send_item(service_item(AL_NONE, 48'd2033000));
		send_item(service_item(AL_RX_DATA, 48'd2033000));
		send_item(service_item(AL_TX_FAILED | AL_TX_SUCCESS, 48'd2066000));
		send_item(service_item(AL_BUS_OFF | AL_RECOVERED | AL_TX_FAILED | AL_TX_SUCCESS |
			AL_RX_DATA, 48'd2070000));
		send_item(service_item(AL_NONE, 48'd12070000));
		send_item(service_item(AL_RECOVERED | AL_TX_FAILED, 48'd12070000));
		send_item(service_item(AL_RECOVERED | AL_RX_DATA, 48'd12070000));
		send_item(service_item(AL_BUS_OFF | AL_RECOVERED, 48'd12080000));
		send_item(sample_item(12'd621, 4'b1110));
		send_item(sample_item(12'd622, 4'b1101));
		send_item(sample_item(12'd2000, 4'b1011));
		send_item(sample_item(12'd3000, 4'b0111));
		send_item(service_item(AL_RECOVERED | AL_TX_SUCCESS, 48'hFFFF_FFFF_FFFF));
		send_item(service_item(AL_NONE, 48'd5));
		send_item(service_item(AL_BUS_OFF, 48'd5));
		send_item(service_item(AL_RECOVERED, 48'h8000_0000_0000));
		send_item(service_item(AL_NONE, 48'd0));

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					set_config(ID_W'($urandom_range(2047)), PERIOD_W'($urandom_range(200, 1)),
						PERIOD_W'($urandom_range(2000, 200)), LIMIT_W'($urandom_range(5, 1)),
						MV_W'($urandom_range(3300)), 1'b0);
					fail_pct = 30;
				end
				1: begin
					set_config(11'h7FF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 12'd3300, 1'b0);
					fail_pct = 80;
				end
				2: begin
					set_config('0, '0, '0, '0, '0, 1'b0);
					fail_pct = 30;
				end
				3: begin
					set_config(ID_W'($urandom_range(2047)), PERIOD_W'($urandom_range(500, 1)),
						PERIOD_W'($urandom_range(5000, 1)), LIMIT_W'($urandom_range(255)),
						12'hFFF, 1'b1);
					fail_pct = 30;
					// run across the top of the time range
					clock_us = 48'hFFFF_FFF0_0000;
				end
				default: begin
					set_config(ID_W'($urandom_range(2047)), 24'd1, 24'd1, 8'd1,
						MV_W'($urandom_range(3300)), 1'b1);
					fail_pct = 40;
				end
			endcase
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if (rnd_idx < RANDOM_ITEMS / 3) begin
					gap_pct   = 35;
					stall_pct = 83;
				end else if (rnd_idx < (2 * RANDOM_ITEMS) / 3) begin
					gap_pct   = 83;
					stall_pct = 35;
				end else begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				// sender holds off until the output side has caught up
				if (ph == 2 && i == RANDOM_ITEMS / (2 * PHASES) && sb.pending() != 0) begin
					in_valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
				send_item(random_item());
				rnd_idx++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.failures += sb.pending();
		if (sb.failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
